### sv/dfps_pkg.sv
// ----------------------------------------------------------------------------
// dfps_pkg
// Shared types and constants of the debounced flight phase sequencer.
// ----------------------------------------------------------------------------
package dfps_pkg;

    // Field widths
    localparam int unsigned TimeW   = 32;
    localparam int unsigned AccelW  = 16;
    localparam int unsigned LightW  = 10;
    localparam int unsigned AltW    = 18;
    localparam int unsigned PhaseW  = 3;

    // Stream and configuration port widths
    localparam int unsigned InDataW  = 80;
    localparam int unsigned OutDataW = 8;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 18;

    // Debounce times in milliseconds
    localparam logic [TimeW-1:0] LaunchHoldMs    = 32'd100;
    localparam logic [TimeW-1:0] ApogeeHoldMs    = 32'd2000;
    localparam logic [TimeW-1:0] DisreefHoldMs   = 32'd1000;
    localparam logic [TimeW-1:0] TouchdownHoldMs = 32'd1000;

    // Flight phase codes
    typedef enum logic [PhaseW-1:0] {
        PH_PAD    = 3'd0,
        PH_ASCENT = 3'd1,
        PH_REEFED = 3'd2,
        PH_MAIN   = 3'd3,
        PH_DOWN   = 3'd4
    } t_phase;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_LAUNCH_ACCEL = 3'd0,
        CFG_APOGEE_LIGHT = 3'd1,
        CFG_DISREEF_ALT  = 3'd2,
        CFG_GROUND_ALT   = 3'd3,
        CFG_TD_BAND      = 3'd4
    } t_cfg_idx;

    // Configuration register set
    typedef struct packed {
        logic signed [AccelW-1:0] launch_accel_threshold;
        logic        [LightW-1:0] apogee_light_threshold;
        logic signed [AltW-1:0]   disreef_altitude;
        logic signed [AltW-1:0]   ground_altitude;
        logic        [AltW-1:0]   touchdown_band;
    } t_cfg;

    // One sensor sample
    typedef struct packed {
        logic signed [AltW-1:0]   altitude;
        logic        [LightW-1:0] light_level;
        logic signed [AccelW-1:0] accel;
        logic        [TimeW-1:0]  time_ms;
    } t_sample;

    // One result
    typedef struct packed {
        logic              pyro_fire;
        logic              launch_pulse;
        logic              in_flight;
        logic [PhaseW-1:0] phase;
    } t_result;

endpackage

### sv/dfps_cfg_regs.sv
// ----------------------------------------------------------------------------
// dfps_cfg_regs
// Threshold registers written through the plain configuration port.
// ----------------------------------------------------------------------------
module dfps_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dfps_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [dfps_pkg::CfgDataW-1:0] i_cfg_data,
    output dfps_pkg::t_cfg                o_cfg
);
    import dfps_pkg::*;

    t_cfg r_cfg;

    // Load the addressed register; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.launch_accel_threshold <= 16'sd2000;
            r_cfg.apogee_light_threshold <= 10'd512;
            r_cfg.disreef_altitude       <= 18'sd1500;
            r_cfg.ground_altitude        <= 18'sd0;
            r_cfg.touchdown_band         <= 18'd20;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LAUNCH_ACCEL: r_cfg.launch_accel_threshold <= i_cfg_data[AccelW-1:0];
                CFG_APOGEE_LIGHT: r_cfg.apogee_light_threshold <= i_cfg_data[LightW-1:0];
                CFG_DISREEF_ALT:  r_cfg.disreef_altitude       <= i_cfg_data[AltW-1:0];
                CFG_GROUND_ALT:   r_cfg.ground_altitude        <= i_cfg_data[AltW-1:0];
                CFG_TD_BAND:      r_cfg.touchdown_band         <= i_cfg_data[AltW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### sv/dfps_phase_core.sv
// ----------------------------------------------------------------------------
// dfps_phase_core
// Phase state, debounce timer and the per-sample transition logic.
// ----------------------------------------------------------------------------
module dfps_phase_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  dfps_pkg::t_sample i_sample,
    input  dfps_pkg::t_cfg    i_cfg,
    output dfps_pkg::t_result o_result,
    output dfps_pkg::t_phase  o_phase
);
    import dfps_pkg::*;

    t_phase            r_phase, n_phase;
    logic              r_qual, n_qual;
    logic [TimeW-1:0]  r_start, n_start;

    logic              cond;
    logic [TimeW-1:0]  hold;
    logic              active;
    logic              met;
    logic [TimeW-1:0]  elapsed;
    logic signed [AltW:0] alt_diff;
    logic [AltW:0]     alt_mag;
    logic              launch;
    logic              pyro;

    // Distance from ground, one bit wider so it never wraps
    assign alt_diff = {i_sample.altitude[AltW-1], i_sample.altitude}
                    - {i_cfg.ground_altitude[AltW-1], i_cfg.ground_altitude};
    assign alt_mag  = alt_diff[AltW] ? (~alt_diff + 1'b1) : alt_diff;
    assign elapsed  = i_sample.time_ms - r_start;

    // Pick the condition and debounce time of the current phase
    always_comb begin
        cond   = 1'b0;
        hold   = LaunchHoldMs;
        active = 1'b1;
        unique case (r_phase)
            PH_PAD: begin
                cond = i_sample.accel > i_cfg.launch_accel_threshold;
                hold = LaunchHoldMs;
            end
            PH_ASCENT: begin
                cond = i_sample.light_level > i_cfg.apogee_light_threshold;
                hold = ApogeeHoldMs;
            end
            PH_REEFED: begin
                cond = i_sample.altitude < i_cfg.disreef_altitude;
                hold = DisreefHoldMs;
            end
            PH_MAIN: begin
                cond = alt_mag <= {1'b0, i_cfg.touchdown_band};
                hold = TouchdownHoldMs;
            end
            default: active = 1'b0;
        endcase
    end

    // Debounce: first true sample starts the timer, false clears it
    always_comb begin
        n_qual  = r_qual;
        n_start = r_start;
        met     = 1'b0;
        if (active) begin
            if (!cond) begin
                n_qual = 1'b0;
            end else if (!r_qual) begin
                n_qual  = 1'b1;
                n_start = i_sample.time_ms;
            end else if (elapsed >= hold) begin
                n_qual = 1'b0;
                met    = 1'b1;
            end
        end
    end

    // Advance the phase when the debounce is met
    always_comb begin
        n_phase = r_phase;
        launch  = 1'b0;
        pyro    = 1'b0;
        if (met) begin
            unique case (r_phase)
                PH_PAD: begin
                    n_phase = PH_ASCENT;
                    launch  = 1'b1;
                end
                PH_ASCENT: n_phase = PH_REEFED;
                PH_REEFED: begin
                    n_phase = PH_MAIN;
                    pyro    = 1'b1;
                end
                PH_MAIN: n_phase = PH_DOWN;
                default: n_phase = r_phase;
            endcase
        end
    end

    // Hold state between samples
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PAD;
            r_qual  <= 1'b0;
            r_start <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_qual  <= n_qual;
            r_start <= n_start;
        end
    end

    assign o_result.phase        = n_phase;
    assign o_result.in_flight    = (n_phase == PH_ASCENT) || (n_phase == PH_REEFED)
                                || (n_phase == PH_MAIN);
    assign o_result.launch_pulse = launch;
    assign o_result.pyro_fire    = pyro;
    assign o_phase               = r_phase;

endmodule

### sv/debounced_flight_phase_sequencer.sv
// ----------------------------------------------------------------------------
// debounced_flight_phase_sequencer
// A sample transaction passes through the input register, then the result
// register. Throughput: one sample per cycle while m_axis_tready is high, set by the single
// compare-and-subtract pass between the two registers; back-pressure stalls it.
// Reset (synchronous, active low): pad idle, timer cleared, thresholds at
// their defaults, both stream registers empty.
// ----------------------------------------------------------------------------
module debounced_flight_phase_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // time_ms[31:0], accel[47:32], light_level[57:48], altitude[75:58], zero pad
    input  logic [dfps_pkg::InDataW-1:0]  s_axis_tdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // phase[2:0], in_flight[3], launch_pulse[4], pyro_fire[5], zero pad
    output logic [dfps_pkg::OutDataW-1:0] m_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic                          i_cfg_we,
    input  logic [dfps_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [dfps_pkg::CfgDataW-1:0] i_cfg_data
);
    import dfps_pkg::*;

    t_cfg    cfg;
    t_sample r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result result;
    t_phase  phase;
    logic    advance;

    dfps_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dfps_phase_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_sample  (r_in),
        .i_cfg     (cfg),
        .o_result  (result),
        .o_phase   (phase)
    );

    // Move a sample on when the result register is free or draining
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= s_axis_tdata[TimeW+AccelW+LightW+AltW-1:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out};

    // Checks
    a_launch_phase : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.launch_pulse) |-> (r_out.phase == PH_ASCENT))
        else $error("launch pulse outside the ascent move");

    a_pyro_phase : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.pyro_fire) |-> (r_out.phase == PH_MAIN && !r_out.launch_pulse))
        else $error("pyro fire outside the disreef move");

    a_in_flight : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.in_flight == ((r_out.phase == PH_ASCENT)
            || (r_out.phase == PH_REEFED) || (r_out.phase == PH_MAIN))))
        else $error("in_flight disagrees with phase");

    a_touchdown_final : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (phase == PH_DOWN) |=> (phase == PH_DOWN))
        else $error("left touchdown");

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Flies one simulated flight through the debounced flight phase sequencer.
// Sensor samples stream in and status transactions stream out, with random
// gaps and stalls on both sides. A short probe table checks the pad phase
// around its edges. After it, random samples with a steered debounce timer
// walk the block through every phase under extreme and random thresholds.
// Every status transaction is compared field by field against the probe
// table's fixed value or a predictor that runs alongside the stimulus.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import dfps_pkg::*;

    // Field ranges
    localparam int AccelMin = -(2 ** (int'(AccelW) - 1));
    localparam int AccelMax = 2 ** (int'(AccelW) - 1) - 1;
    localparam int LightMax = 2 ** int'(LightW) - 1;
    localparam int AltMin   = -(2 ** (int'(AltW) - 1));
    localparam int AltMax   = 2 ** (int'(AltW) - 1) - 1;
    localparam int BandMax  = 2 ** int'(AltW) - 1;

    // Register values after reset
    localparam int LaunchAccelInit = 2000;
    localparam int ApogeeLightInit = 512;
    localparam int DisreefAltInit  = 1500;
    localparam int GroundAltInit   = 0;
    localparam int TdBandInit      = 20;

    // Run shape
    localparam int TargetSamples = 650;
    localparam int SegLen        = 45;
    localparam int NumSegs       = 3;
    localparam int StallLimit    = 4000;
    localparam int MaxReports    = 10;

    typedef struct {
        t_sample smp;
        bit      fixed;
        t_phase  want;
    } t_probe_row;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic [InDataW-1:0]   s_axis_tdata  = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [OutDataW-1:0]  m_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CfgIdxW-1:0]   i_cfg_index   = '0;
    logic [CfgDataW-1:0]  i_cfg_data    = '0;

    // Predictor state and register shadow
    t_phase      fl_phase;
    bit          qual_on;
    logic [31:0] qual_t0;
    t_cfg        cfg_shadow;

    t_result     status_due[$];
    t_probe_row  probe_rows[$];
    bit          no_idle = 1'b0;
    int          rx_wait = 0;
    int          idle_cycles = 0;
    int          samples_sent = 0;
    int          results_checked = 0;
    int          reg_writes = 0;
    int          failures = 0;
    int          launches_seen = 0;
    int          pyros_seen = 0;

    debounced_flight_phase_sequencer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Debounce time of the move out of a phase
    function automatic logic [31:0] hold_for(input t_phase p);
        case (p)
            PH_PAD:    return LaunchHoldMs;
            PH_ASCENT: return ApogeeHoldMs;
            PH_REEFED: return DisreefHoldMs;
            default:   return TouchdownHoldMs;
        endcase
    endfunction

    // Advance the flight by one sample and return the status it produces
    function automatic t_result advance_flight(input t_sample s);
        t_result r;
        bit      cond;
        bit      moved;
        int      alt_dev;
        cond  = 1'b0;
        moved = 1'b0;
        r     = '0;
        case (fl_phase)
            PH_PAD:    cond = $signed(s.accel) > $signed(cfg_shadow.launch_accel_threshold);
            PH_ASCENT: cond = s.light_level > cfg_shadow.apogee_light_threshold;
            PH_REEFED: cond = $signed(s.altitude) < $signed(cfg_shadow.disreef_altitude);
            PH_MAIN: begin
                alt_dev = int'($signed(s.altitude)) - int'($signed(cfg_shadow.ground_altitude));
                if (alt_dev < 0) alt_dev = -alt_dev;
                cond = alt_dev <= int'(cfg_shadow.touchdown_band);
            end
            default: ;
        endcase
        // Debounce: first true sample arms the timer, a false one drops it
        if (fl_phase inside {PH_PAD, PH_ASCENT, PH_REEFED, PH_MAIN}) begin
            if (!cond) begin
                qual_on = 1'b0;
            end else if (!qual_on) begin
                qual_on = 1'b1;
                qual_t0 = s.time_ms;
            end else if (s.time_ms - qual_t0 >= hold_for(fl_phase)) begin
                qual_on = 1'b0;
                moved   = 1'b1;
            end
        end
        if (moved) begin
            case (fl_phase)
                PH_PAD: begin
                    fl_phase       = PH_ASCENT;
                    r.launch_pulse = 1'b1;
                end
                PH_ASCENT: fl_phase = PH_REEFED;
                PH_REEFED: begin
                    fl_phase    = PH_MAIN;
                    r.pyro_fire = 1'b1;
                end
                default: fl_phase = PH_DOWN;
            endcase
        end
        r.phase     = fl_phase;
        r.in_flight = fl_phase inside {PH_ASCENT, PH_REEFED, PH_MAIN};
        return r;
    endfunction

    // Value in [lo, hi], with the edges drawn more often
    function automatic int pick(input int lo, input int hi);
        case ($urandom_range(0, 7))
            0:       return lo;
            1:       return hi;
            default: return lo + int'($urandom_range(0, hi - lo));
        endcase
    endfunction

    // Sensor reading that makes the current phase's condition true or false
    function automatic t_sample make_reading(input bit want_true);
        t_sample s;
        int      thr;
        int      lo;
        int      hi;
        s.time_ms     = '0;
        s.accel       = AccelW'($urandom);
        s.light_level = LightW'($urandom);
        s.altitude    = AltW'($urandom);
        case (fl_phase)
            PH_PAD: begin
                thr = int'($signed(cfg_shadow.launch_accel_threshold));
                if (!want_true) s.accel = AccelW'(pick(AccelMin, thr));
                else if (thr < AccelMax) s.accel = AccelW'(pick(thr + 1, AccelMax));
            end
            PH_ASCENT: begin
                thr = int'(cfg_shadow.apogee_light_threshold);
                if (!want_true) s.light_level = LightW'(pick(0, thr));
                else if (thr < LightMax) s.light_level = LightW'(pick(thr + 1, LightMax));
            end
            PH_REEFED: begin
                thr = int'($signed(cfg_shadow.disreef_altitude));
                if (!want_true) s.altitude = AltW'(pick(thr, AltMax));
                else if (thr > AltMin) s.altitude = AltW'(pick(AltMin, thr - 1));
            end
            PH_MAIN: begin
                thr = int'($signed(cfg_shadow.ground_altitude));
                lo  = thr - int'(cfg_shadow.touchdown_band);
                hi  = thr + int'(cfg_shadow.touchdown_band);
                if (lo < AltMin) lo = AltMin;
                if (hi > AltMax) hi = AltMax;
                if (want_true) begin
                    s.altitude = AltW'(pick(lo, hi));
                end else if (lo > AltMin && (hi == AltMax || $urandom_range(0, 1) == 0)) begin
                    s.altitude = AltW'(pick(AltMin, lo - 1));
                end else if (hi < AltMax) begin
                    s.altitude = AltW'(pick(hi + 1, AltMax));
                end
            end
            default: ;
        endcase
        return s;
    endfunction

    function automatic t_probe_row mk_row(input logic [31:0] stamp, input int accel,
                                          input int light, input int alt,
                                          input bit fixed, input t_phase want);
        t_probe_row row;
        row.smp.time_ms     = stamp;
        row.smp.accel       = AccelW'(accel);
        row.smp.light_level = LightW'(light);
        row.smp.altitude    = AltW'(alt);
        row.fixed           = fixed;
        row.want            = want;
        return row;
    endfunction

    // Send one sample transaction and queue the status it must produce
    task automatic send_sample(input t_sample smp, input bit fixed, input t_result typed);
        int unsigned gap;
        t_result     predicted;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {{(InDataW - $bits(t_sample)){1'b0}}, smp};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = advance_flight(smp);
        status_due.push_back(fixed ? typed : predicted);
        samples_sent++;
        if (samples_sent % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
    endtask

    // Write one register; bits above the register width are random junk
    task automatic put_reg(input logic [CfgIdxW-1:0] idx, input int value,
                           input int unsigned width);
        logic [CfgDataW-1:0] mask;
        logic [CfgDataW-1:0] d;
        mask = CfgDataW'((1 << width) - 1);
        d    = (CfgDataW'($urandom) & ~mask) | (CfgDataW'(value) & mask);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        case (idx)
            CFG_LAUNCH_ACCEL: cfg_shadow.launch_accel_threshold = d[AccelW-1:0];
            CFG_APOGEE_LIGHT: cfg_shadow.apogee_light_threshold = d[LightW-1:0];
            CFG_DISREEF_ALT:  cfg_shadow.disreef_altitude       = d[AltW-1:0];
            CFG_GROUND_ALT:   cfg_shadow.ground_altitude        = d[AltW-1:0];
            CFG_TD_BAND:      cfg_shadow.touchdown_band         = d[AltW-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Drain the block, then load the thresholds for one segment of a phase
    task automatic apply_setting(input t_phase ph, input int seg);
        s_axis_tvalid <= 1'b0;
        while (status_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        // Unused index: must leave every register alone
        put_reg(CfgIdxW'(CFG_TD_BAND + 1 + $urandom_range(0, 2)), int'($urandom), CfgDataW);
        case (ph)
            PH_PAD:
                put_reg(CFG_LAUNCH_ACCEL, seg == 0 ? AccelMax :
                        seg == 1 ? AccelMin : pick(AccelMin, AccelMax - 1), AccelW);
            PH_ASCENT:
                put_reg(CFG_APOGEE_LIGHT, seg == 0 ? LightMax :
                        seg == 1 ? 0 : pick(0, LightMax - 1), LightW);
            PH_REEFED:
                put_reg(CFG_DISREEF_ALT, seg == 0 ? AltMin :
                        seg == 1 ? AltMax : pick(AltMin + 1, AltMax), AltW);
            PH_MAIN: begin
                put_reg(CFG_GROUND_ALT, seg == 0 ? AltMax :
                        seg == 1 ? AltMin : pick(AltMin, AltMax), AltW);
                put_reg(CFG_TD_BAND, seg == 0 ? 0 : seg == 1 ? BandMax :
                        ($urandom_range(0, 1) == 0 ? pick(0, 500) : pick(0, BandMax)), AltW);
            end
            default: begin
                put_reg(CFG_LAUNCH_ACCEL, pick(AccelMin, AccelMax), AccelW);
                put_reg(CFG_APOGEE_LIGHT, pick(0, LightMax), LightW);
                put_reg(CFG_DISREEF_ALT, pick(AltMin, AltMax), AltW);
                put_reg(CFG_GROUND_ALT, pick(AltMin, AltMax), AltW);
                put_reg(CFG_TD_BAND, pick(0, BandMax), AltW);
            end
        endcase
        i_cfg_we <= 1'b0;
    endtask

    // Stimulus: probe table, then one steered random flight
    initial begin : stimulus
        t_sample     smp;
        t_phase      seg_phase;
        int          in_phase;
        bit          forced;
        bit          want;
        logic [31:0] hold;
        logic [31:0] stamp;
        logic [31:0] now_ms;

        fl_phase   = PH_PAD;
        qual_on    = 1'b0;
        qual_t0    = '0;
        cfg_shadow.launch_accel_threshold = AccelW'(LaunchAccelInit);
        cfg_shadow.apogee_light_threshold = LightW'(ApogeeLightInit);
        cfg_shadow.disreef_altitude       = AltW'(DisreefAltInit);
        cfg_shadow.ground_altitude        = AltW'(GroundAltInit);
        cfg_shadow.touchdown_band         = AltW'(TdBandInit);

        // Pad probes under reset thresholds: floor and ceiling values, timer
        // armed across the timestamp wrap, threshold equality, zero elapsed
        probe_rows.push_back(mk_row(32'h0000_0000, AccelMin, 0, AltMin, 1, PH_PAD));
        probe_rows.push_back(mk_row(32'hFFFF_FFFF, AccelMax, LightMax, AltMax, 1, PH_PAD));
        probe_rows.push_back(mk_row(32'h0000_0062, 2001, 512, 1500, 1, PH_PAD));
        probe_rows.push_back(mk_row(32'h0000_0063, 2000, 0, 0, 1, PH_PAD));
        probe_rows.push_back(mk_row(32'd500, 2001, LightMax, -1, 1, PH_PAD));
        probe_rows.push_back(mk_row(32'd500, AccelMax, 0, 0, 1, PH_PAD));
        probe_rows.push_back(mk_row(32'd599, 16384, 511, 1499, 0, PH_PAD));
        probe_rows.push_back(mk_row(32'd599, -1, 513, -1501, 0, PH_PAD));
        probe_rows.push_back(mk_row(32'd1000, 16'h5555, 10'h2AA, 18'h15555, 0, PH_PAD));
        probe_rows.push_back(mk_row(32'd1050, 16'h2AAA, 10'h155, -87382, 0, PH_PAD));
        probe_rows.push_back(mk_row(32'd1049, 1999, 0, 0, 0, PH_PAD));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probe_rows[i]) begin
            send_sample(probe_rows[i].smp, probe_rows[i].fixed,
                        '{pyro_fire: 1'b0, launch_pulse: 1'b0, in_flight: 1'b0,
                          phase: probe_rows[i].want});
        end

        // Random flight: three threshold segments per phase, then force the move
        seg_phase = PH_PAD;
        in_phase  = 0;
        now_ms    = 32'd2000;
        while (samples_sent < TargetSamples) begin
            if (fl_phase != seg_phase) begin
                seg_phase = fl_phase;
                in_phase  = 0;
            end
            if (in_phase % SegLen == 0 && in_phase / SegLen < NumSegs)
                apply_setting(fl_phase, in_phase / SegLen);

            forced = (in_phase >= SegLen * NumSegs) && fl_phase != PH_DOWN;
            hold   = hold_for(fl_phase);
            want   = forced || ($urandom_range(0, 9) < 6);
            smp    = make_reading(want);

            // Timestamp: steady steps, exact debounce edges, rare wild jumps;
            // forced launch and disreef moves use a backward step
            if (forced && qual_on) begin
                if (fl_phase inside {PH_PAD, PH_REEFED})
                    stamp = qual_t0 - 32'd1 - $urandom_range(0, 1000);
                else
                    stamp = qual_t0 + hold + $urandom_range(0, 20);
            end else if ($urandom_range(0, 29) == 0) begin
                stamp = $urandom;
            end else if (qual_on && $urandom_range(0, 4) == 0) begin
                stamp = qual_t0 + hold - $urandom_range(0, 1);
            end else begin
                stamp = now_ms + $urandom_range(0, hold / 4 + 1);
            end
            smp.time_ms = stamp;

            // Glitch the condition to hold the phase until its budget runs out
            if (!forced && want && qual_on && fl_phase != PH_DOWN &&
                stamp - qual_t0 >= hold && $urandom_range(0, 9) != 0) begin
                smp         = make_reading(1'b0);
                smp.time_ms = stamp;
            end

            send_sample(smp, 1'b0, '0);
            now_ms = stamp;
            in_phase++;
        end
        s_axis_tvalid <= 1'b0;

        // Wait out the remaining status transactions, then look for strays
        while (status_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Run: %0d sensor samples, %0d status transactions, %0d register writes",
                 samples_sent, results_checked, reg_writes);
        $display("Flight: %0d launch pulses, %0d pyro fires, final phase %s, %0d mismatches",
                 launches_seen, pyros_seen, fl_phase.name(), failures);
        if (failures == 0) begin
            $display("[debounced_flight_phase_sequencer] OK");
        end else begin
            $display("[debounced_flight_phase_sequencer] ERROR");
        end
        $finish;
    end

    // Status sink: random stalls, field-by-field check against the oldest entry
    always @(posedge i_clk) begin : status_sink
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
                results_checked++;
                if (got.launch_pulse) launches_seen++;
                if (got.pyro_fire) pyros_seen++;
                if (status_due.size() == 0) begin
                    failures++;
                    if (failures <= MaxReports)
                        $display("%0t: status with nothing pending: phase=%0d fl=%b lp=%b py=%b",
                                 $realtime, got.phase, got.in_flight, got.launch_pulse,
                                 got.pyro_fire);
                end else begin
                    want = status_due.pop_front();
                    if (got.phase !== want.phase || got.in_flight !== want.in_flight ||
                        got.launch_pulse !== want.launch_pulse ||
                        got.pyro_fire !== want.pyro_fire) begin
                        failures++;
                        if (failures <= MaxReports)
                            $display({"%0t: status mismatch exp phase=%0d fl=%b lp=%b py=%b",
                                      " got phase=%0d fl=%b lp=%b py=%b"},
                                     $realtime, want.phase, want.in_flight, want.launch_pulse,
                                     want.pyro_fire, got.phase, got.in_flight,
                                     got.launch_pulse, got.pyro_fire);
                    end
                end
                rx_wait = no_idle ? 0 : $urandom_range(0, 9);
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            m_axis_tready <= (rx_wait == 0);
        end
    end

    // Watchdog: stop when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= StallLimit) begin
            $display("%0t: no transaction for %0d cycles, %0d status transactions pending",
                     $realtime, StallLimit, status_due.size());
            $display("[debounced_flight_phase_sequencer] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
